@@ src/vldp_pkg.sv @@
package vldp_pkg;

    // Character codes (compared after folding lower case to upper case).
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Field kinds.
    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_NORMAL   = 2'd1;
    localparam logic [1:0] KIND_TEXTURE  = 2'd2;
    localparam logic [1:0] KIND_COLOR    = 2'd3;

    // Triangle types.
    localparam logic [1:0] PRIM_NONE  = 2'd0;
    localparam logic [1:0] PRIM_LIST  = 2'd1;
    localparam logic [1:0] PRIM_STRIP = 2'd2;

    // Status codes. Count and too-many codes for N, T and C follow the P codes
    // in steps of two.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_EMPTY      = 4'd1;
    localparam logic [3:0] ST_UNEXP_END  = 4'd2;
    localparam logic [3:0] ST_BAD_STRUCT = 4'd3;
    localparam logic [3:0] ST_BAD_TYPE   = 4'd4;
    localparam logic [3:0] ST_UNKNOWN    = 4'd5;
    localparam logic [3:0] ST_P_COUNT    = 4'd6;
    localparam logic [3:0] ST_P_MANY     = 4'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One queue entry: an optional field record and an optional status word.
    typedef struct packed {
        logic       rec_v;
        logic [1:0] kind;
        logic [3:0] slot;
        logic [9:0] offset;
        logic [2:0] comp;
        logic       sta_v;
        logic [3:0] status;
        logic [1:0] tri_kind;
        logic [9:0] stride;
        logic [7:0] err_at;
    } vldp_entry_t;

    typedef struct packed {
        logic        push;
        vldp_entry_t entry;
    } vldp_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } vldp_qstat_t;

    typedef struct packed {
        logic       is_status;
        logic [1:0] field_kind;
        logic [3:0] slot;
        logic [9:0] offset_bytes;
        logic [2:0] components;
        logic [3:0] status;
        logic [1:0] tri_type;
        logic [9:0] stride_bytes;
        logic [7:0] error_index;
    } vldp_word_t;

endpackage

@@ src/vldp_if.sv @@
interface vldp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_text;

    modport source (output valid, output char_code, output has_char, output end_of_text,
                    input ready);
    modport sink (input valid, input char_code, input has_char, input end_of_text,
                  output ready);
endinterface

interface vldp_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [1:0] field_kind;
    logic [3:0] slot;
    logic [9:0] offset_bytes;
    logic [2:0] components;
    logic [3:0] status;
    logic [1:0] tri_type;
    logic [9:0] stride_bytes;
    logic [7:0] error_index;

    modport source (output valid, output is_status, output field_kind, output slot,
                    output offset_bytes, output components, output status,
                    output tri_type, output stride_bytes, output error_index,
                    input ready);
    modport sink (input valid, input is_status, input field_kind, input slot,
                  input offset_bytes, input components, input status,
                  input tri_type, input stride_bytes, input error_index,
                  output ready);
endinterface

@@ src/vldp_front.sv @@
module vldp_front
    import vldp_pkg::*;
#(
    parameter int MAX_REPEAT_FIELDS = 16,
    parameter int MAX_TEXT_LENGTH   = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    vldp_in_if.sink      in_ch,
    output vldp_push_t   push,
    input  vldp_qstat_t  qstat
);

    typedef enum logic [2:0] {
        PH_EXPECT_I,
        PH_EXPECT_TYPE,
        PH_FIELDS,
        PH_EXPECT_DIGIT,
        PH_DONE,
        PH_ERROR
    } phase_t;

    localparam logic [7:0] IDX_MAX   = 8'(MAX_TEXT_LENGTH - 1);
    localparam logic [4:0] REP_LIMIT = 5'(MAX_REPEAT_FIELDS);

    phase_t      phase_reg, phase_next;
    logic [1:0]  tri_reg, tri_next;
    logic [1:0]  pending_reg, pending_next;
    logic [9:0]  stride_reg, stride_next;
    logic [4:0]  used_reg [4];
    logic [4:0]  used_next [4];
    logic [3:0]  err_code_reg, err_code_next;
    logic [7:0]  err_at_reg, err_at_next;
    logic [7:0]  char_idx_reg, char_idx_next;
    logic [7:0]  letter_at_reg, letter_at_next;

    logic        accept;
    logic [7:0]  ch;
    logic [7:0]  up;
    logic        is_space;
    logic [4:0]  kind_limit;
    vldp_entry_t entry;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !qstat.full;
    assign ch           = in_ch.char_code;
    assign up           = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_GAP : ch;
    assign is_space     = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    assign kind_limit   = pending_reg[1] ? REP_LIMIT : 5'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        tri_next       = tri_reg;
        pending_next   = pending_reg;
        stride_next    = stride_reg;
        used_next      = used_reg;
        err_code_next  = err_code_reg;
        err_at_next    = err_at_reg;
        char_idx_next  = char_idx_reg;
        letter_at_next = letter_at_reg;
        entry          = '0;

        if (in_ch.has_char)
        begin
            if (char_idx_reg < IDX_MAX)
            begin
                char_idx_next = char_idx_reg + 8'd1;
            end
            case (phase_reg)
                PH_EXPECT_I:
                begin
                    if (!is_space)
                    begin
                        if (up == CH_I)
                        begin
                            letter_at_next = char_idx_reg;
                            phase_next     = PH_EXPECT_TYPE;
                        end
                        else
                        begin
                            err_code_next = ST_BAD_STRUCT;
                            err_at_next   = char_idx_reg;
                            phase_next    = PH_ERROR;
                        end
                    end
                end
                PH_EXPECT_TYPE:
                begin
                    if (!is_space)
                    begin
                        if (up == CH_L)
                        begin
                            tri_next   = PRIM_LIST;
                            phase_next = PH_FIELDS;
                        end
                        else if (up == CH_S)
                        begin
                            tri_next   = PRIM_STRIP;
                            phase_next = PH_FIELDS;
                        end
                        else
                        begin
                            err_code_next = ST_BAD_TYPE;
                            err_at_next   = char_idx_reg;
                            phase_next    = PH_ERROR;
                        end
                    end
                end
                PH_FIELDS:
                begin
                    if (!is_space)
                    begin
                        if (up == CH_HASH)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (up == CH_P || up == CH_N || up == CH_T || up == CH_C)
                        begin
                            if (up == CH_P)
                            begin
                                pending_next = KIND_POSITION;
                            end
                            else if (up == CH_N)
                            begin
                                pending_next = KIND_NORMAL;
                            end
                            else if (up == CH_T)
                            begin
                                pending_next = KIND_TEXTURE;
                            end
                            else
                            begin
                                pending_next = KIND_COLOR;
                            end
                            letter_at_next = char_idx_reg;
                            phase_next     = PH_EXPECT_DIGIT;
                        end
                        else
                        begin
                            err_code_next = ST_UNKNOWN;
                            err_at_next   = char_idx_reg;
                            phase_next    = PH_ERROR;
                        end
                    end
                end
                PH_EXPECT_DIGIT:
                begin
                    // The digit is taken as it stands: a space here is an error too.
                    if (ch < CH_ONE || ch > CH_FOUR)
                    begin
                        err_code_next = ST_P_COUNT + {1'b0, pending_reg, 1'b0};
                        err_at_next   = letter_at_reg;
                        phase_next    = PH_ERROR;
                    end
                    else if (used_reg[pending_reg] >= kind_limit)
                    begin
                        err_code_next = ST_P_MANY + {1'b0, pending_reg, 1'b0};
                        err_at_next   = letter_at_reg;
                        phase_next    = PH_ERROR;
                    end
                    else
                    begin
                        entry.rec_v  = 1'b1;
                        entry.kind   = pending_reg;
                        entry.slot   = used_reg[pending_reg][3:0];
                        entry.offset = stride_reg;
                        entry.comp   = 3'(ch - CH_ZERO);
                        stride_next  = stride_reg + {5'd0, 3'(ch - CH_ZERO), 2'b00};
                        used_next[pending_reg] = used_reg[pending_reg] + 5'd1;
                        phase_next   = PH_FIELDS;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (in_ch.end_of_text)
        begin
            entry.sta_v    = 1'b1;
            entry.tri_kind = tri_next;
            entry.stride   = stride_next;
            case (phase_next)
                PH_ERROR:
                begin
                    entry.status = err_code_next;
                    entry.err_at = err_at_next;
                end
                PH_EXPECT_I:
                begin
                    entry.status = ST_EMPTY;
                end
                PH_EXPECT_TYPE, PH_EXPECT_DIGIT:
                begin
                    entry.status = ST_UNEXP_END;
                    entry.err_at = letter_at_next;
                end
                default:
                begin
                    entry.status = ST_OK;
                end
            endcase

            // The next descriptor starts from a clean state.
            phase_next     = PH_EXPECT_I;
            tri_next       = PRIM_NONE;
            pending_next   = KIND_POSITION;
            stride_next    = '0;
            used_next      = '{default: '0};
            err_code_next  = ST_OK;
            err_at_next    = '0;
            char_idx_next  = '0;
            letter_at_next = '0;
        end
    end

    assign push.push  = accept && (entry.rec_v || entry.sta_v);
    assign push.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EXPECT_I;
            tri_reg       <= PRIM_NONE;
            pending_reg   <= KIND_POSITION;
            stride_reg    <= '0;
            used_reg      <= '{default: '0};
            err_code_reg  <= ST_OK;
            err_at_reg    <= '0;
            char_idx_reg  <= '0;
            letter_at_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            tri_reg       <= tri_next;
            pending_reg   <= pending_next;
            stride_reg    <= stride_next;
            used_reg      <= used_next;
            err_code_reg  <= err_code_next;
            err_at_reg    <= err_at_next;
            char_idx_reg  <= char_idx_next;
            letter_at_reg <= letter_at_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.end_of_text) |=> (phase_reg == PH_EXPECT_I && stride_reg == '0))
        else $error("state not cleared after final word");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_ch.end_of_text && phase_reg == PH_ERROR) |=> (phase_reg == PH_ERROR))
        else $error("error phase left before final word");

    a_end_pushes_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.end_of_text) |-> (push.push && push.entry.sta_v))
        else $error("final word produced no status");

endmodule

@@ src/vldp_queue.sv @@
module vldp_queue
    import vldp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vldp_push_t  push,
    input  logic        pop,
    output vldp_entry_t head,
    output vldp_qstat_t qstat
);

    vldp_entry_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;

    assign qstat.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push.push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push.push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !qstat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule

@@ src/vldp_back.sv @@
module vldp_back
    import vldp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vldp_entry_t head,
    input  vldp_qstat_t qstat,
    output logic        pop,
    vldp_out_if.source  out_ch
);

    logic       out_valid_reg, out_valid_next;
    vldp_word_t out_word_reg, out_word_next;
    logic       rec_done_reg, rec_done_next;
    logic       load_ok;

    assign load_ok = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        rec_done_next  = rec_done_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = 1'b0;
            if (!qstat.empty)
            begin
                out_valid_next = 1'b1;
                out_word_next  = '0;
                if (head.rec_v && !rec_done_reg)
                begin
                    out_word_next.field_kind   = head.kind;
                    out_word_next.slot         = head.slot;
                    out_word_next.offset_bytes = head.offset;
                    out_word_next.components   = head.comp;
                    if (head.sta_v)
                    begin
                        rec_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    out_word_next.is_status    = 1'b1;
                    out_word_next.status       = head.status;
                    out_word_next.tri_type     = head.tri_kind;
                    out_word_next.stride_bytes = head.stride;
                    out_word_next.error_index  = head.err_at;
                    rec_done_next = 1'b0;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rec_done_reg  <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rec_done_reg  <= rec_done_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.is_status    = out_word_reg.is_status;
    assign out_ch.field_kind   = out_word_reg.field_kind;
    assign out_ch.slot         = out_word_reg.slot;
    assign out_ch.offset_bytes = out_word_reg.offset_bytes;
    assign out_ch.components   = out_word_reg.components;
    assign out_ch.status       = out_word_reg.status;
    assign out_ch.tri_type     = out_word_reg.tri_type;
    assign out_ch.stride_bytes = out_word_reg.stride_bytes;
    assign out_ch.error_index  = out_word_reg.error_index;

    a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rec_done_reg |-> (!qstat.empty && head.rec_v && head.sta_v))
        else $error("record sent flag set without a split entry at the head");

endmodule

@@ src/vertex_layout_descriptor_parser_top.sv @@
// Vertex-layout descriptor parser.
//
// Input channel in_ch carries one character word per handshake: char_code,
// has_char (0 marks a word with no character) and end_of_text on the last
// word of a descriptor. Output channel out_ch carries field records
// (is_status = 0) and, after the last word of each descriptor, one status
// word (is_status = 1) with the triangle type, stride and error index.
//
// The front parser takes one word per cycle and keeps ready high unless the
// four-entry queue to the output stage is full. The queue holds a word from
// the edge that accepted it, and the output register loads it from the queue
// head as soon as the register is free. Each queue entry yields one output
// word, except the final word when it also completes a field: it then yields
// a field record and then a status word. A stalled receiver first fills the
// output register, then the queue, and only then drops in_ch.ready; nothing
// is lost or repeated.
//
// Reset clears the parser to the start of a descriptor and empties the
// queue and the output register. No clearing pass is needed.
module vertex_layout_descriptor_parser_top
    import vldp_pkg::*;
#(
    parameter int MAX_REPEAT_FIELDS = 16,
    parameter int MAX_TEXT_LENGTH   = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    vldp_in_if.sink     in_ch,
    vldp_out_if.source  out_ch
);

    vldp_push_t  push;
    vldp_qstat_t qstat;
    vldp_entry_t head;
    logic        pop;

    vldp_front #(
        .MAX_REPEAT_FIELDS (MAX_REPEAT_FIELDS),
        .MAX_TEXT_LENGTH   (MAX_TEXT_LENGTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .push  (push),
        .qstat (qstat)
    );

    vldp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    vldp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ sim/vertex_layout_descriptor_parser_top_test.sv @@
`timescale 1ns / 100ps

module vertex_layout_descriptor_parser_top_test;
    import vldp_pkg::*;

    // The package names the position codes only; the other kinds follow in
    // steps of two.
    localparam logic [3:0] ST_N_COUNT = ST_P_COUNT + 4'd2;
    localparam logic [3:0] ST_N_MANY  = ST_P_MANY + 4'd2;
    localparam logic [3:0] ST_T_COUNT = ST_P_COUNT + 4'd4;
    localparam logic [3:0] ST_T_MANY  = ST_P_MANY + 4'd4;
    localparam logic [3:0] ST_C_COUNT = ST_P_COUNT + 4'd6;
    localparam logic [3:0] ST_C_MANY  = ST_P_MANY + 4'd6;

    localparam int REPEAT_LIMIT = 16;
    localparam int TOTAL_WORDS  = 1350;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT  = 2000;

    // Parser position within one descriptor, as tracked by the predictor.
    typedef enum logic [2:0] {
        AWAIT_I,
        AWAIT_TRI,
        AWAIT_FIELD,
        AWAIT_DIGIT,
        PARSE_DONE,
        PARSE_ERROR
    } parse_phase_t;

    // Ways in which a random descriptor departs from a well-formed one.
    typedef enum int {
        FLAW_NONE,
        FLAW_GARBAGE,
        FLAW_TYPE,
        FLAW_DIGIT,
        FLAW_LETTER,
        FLAW_COMMENT,
        FLAW_TRUNCATE
    } layout_flaw_t;

    // Receiver behaviors; each one holds for a random span of cycles.
    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_CYCLIC,
        READY_BURSTY
    } ready_style_t;

    // One directed descriptor. Spaces numbering pad are slipped in before the
    // last character, which pushes the character index into saturation. When
    // blank_end is set, the descriptor is closed by a word with no character.
    // When fixed is set, the status word is typed in here rather than predicted.
    typedef struct {
        string      text;
        int         pad;
        bit         blank_end;
        bit         fixed;
        logic [3:0] st;
        logic [1:0] tri_k;
        int         stride;
        int         err_at;
    } layout_case_t;

    // A status word stated up front for one descriptor, in the order sent.
    typedef struct packed {
        logic       fixed;
        vldp_word_t word;
    } status_claim_t;

    logic clk;
    logic rst_n;

    vldp_in_if  in_ch ();
    vldp_out_if out_ch ();

    vertex_layout_descriptor_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    layout_case_t layout_cases [25] = '{
        // Empty text, closed by a word that carries no character.
        '{"", 0, 1'b1, 1'b1, ST_EMPTY, PRIM_NONE, 0, 0},
        // Whitespace only counts as empty as well.
        '{" \t\n", 0, 1'b0, 1'b1, ST_EMPTY, PRIM_NONE, 0, 0},
        // Triangle type missing: the error points at the 'I'.
        '{" I", 0, 1'b0, 1'b1, ST_UNEXP_END, PRIM_NONE, 0, 1},
        '{"X", 0, 1'b0, 1'b1, ST_BAD_STRUCT, PRIM_NONE, 0, 0},
        // Everything after the bad type is ignored.
        '{"IQ L P1", 0, 1'b0, 1'b1, ST_BAD_TYPE, PRIM_NONE, 0, 1},
        '{"IL", 0, 1'b0, 1'b1, ST_OK, PRIM_LIST, 0, 0},
        '{"is", 0, 1'b1, 1'b1, ST_OK, PRIM_STRIP, 0, 0},
        // Digit missing: the error points at the field letter.
        '{"ILP", 0, 1'b0, 1'b1, ST_UNEXP_END, PRIM_LIST, 0, 2},
        '{"ILP5", 0, 1'b0, 1'b1, ST_P_COUNT, PRIM_LIST, 0, 2},
        // A space between letter and digit is a bad digit too.
        '{"ISN 1", 0, 1'b0, 1'b1, ST_N_COUNT, PRIM_STRIP, 0, 2},
        '{"ILT0", 0, 1'b0, 1'b1, ST_T_COUNT, PRIM_LIST, 0, 2},
        '{"ILc:", 0, 1'b0, 1'b1, ST_C_COUNT, PRIM_LIST, 0, 2},
        '{"ILP1P1", 0, 1'b0, 1'b1, ST_P_MANY, PRIM_LIST, 4, 4},
        '{"ILN4N2", 0, 1'b0, 1'b1, ST_N_MANY, PRIM_LIST, 16, 4},
        '{"ILZ", 0, 1'b0, 1'b1, ST_UNKNOWN, PRIM_LIST, 0, 2},
        '{"IL\377", 0, 1'b0, 1'b1, ST_UNKNOWN, PRIM_LIST, 0, 2},
        // Mixed case, whitespace between fields, junk after the comment mark.
        '{"IL p4 n3\tt2 c1 # x?", 0, 1'b0, 1'b0, ST_OK, PRIM_NONE, 0, 0},
        // The final character completes a field: record and status together.
        '{"ILP2", 0, 1'b0, 1'b1, ST_OK, PRIM_LIST, 8, 0},
        '{"IS#P9", 0, 1'b1, 1'b1, ST_OK, PRIM_STRIP, 0, 0},
        '{"ILC3", 0, 1'b1, 1'b0, ST_OK, PRIM_NONE, 0, 0},
        // Every kind filled to its limit with four components: largest stride.
        '{"ILP4N4C4C4C4C4C4C4C4C4C4C4C4C4C4C4C4C4T4T4T4T4T4T4T4T4T4T4T4T4T4T4T4T4",
          0, 1'b0, 1'b1, ST_OK, PRIM_LIST, 544, 0},
        // A seventeenth texture, and a seventeenth color in lower case.
        '{"IST1T1T1T1T1T1T1T1T1T1T1T1T1T1T1T1T1",
          0, 1'b0, 1'b1, ST_T_MANY, PRIM_STRIP, 64, 34},
        '{"ilc2c2c2c2c2c2c2c2c2c2c2c2c2c2c2c2c2",
          0, 1'b0, 1'b1, ST_C_MANY, PRIM_LIST, 128, 34},
        // Long texts: the error index saturates at the last character index.
        '{"ILX", 300, 1'b0, 1'b1, ST_UNKNOWN, PRIM_LIST, 0, 255},
        '{"ILP", 260, 1'b0, 1'b1, ST_UNEXP_END, PRIM_LIST, 0, 255}
    };

    logic [7:0] field_letters [4] = '{CH_P, CH_N, CH_T, CH_C};

    // Predictor state for the descriptor in flight.
    parse_phase_t ph;
    logic [1:0]   tri_sel;
    logic [1:0]   pend_kind;
    logic [9:0]   stride;
    logic [4:0]   used_count [4];
    logic [3:0]   err_code;
    logic [7:0]   err_pos;
    logic [7:0]   char_pos;
    logic [7:0]   letter_pos;

    vldp_word_t    expected_words [$];
    status_claim_t claimed_status [$];
    logic [7:0]    layout_chars [$];

    vldp_word_t seen_word;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    int         words_sent = 0;

    // ------------------------------------------------------------------
    // Clock: 20 ns period.
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor. It follows the parser one character word at a time and
    // queues the field records and status word that each word must produce.
    // ------------------------------------------------------------------
    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_parser();
        ph = AWAIT_I;
        tri_sel = PRIM_NONE;
        pend_kind = KIND_POSITION;
        stride = '0;
        foreach (used_count[k])
            used_count[k] = '0;
        err_code = ST_OK;
        err_pos = '0;
        char_pos = '0;
        letter_pos = '0;
    endfunction

    // The first error freezes the parser until the end of the text.
    function automatic void set_error(logic [3:0] code, logic [7:0] at);
        err_code = code;
        err_pos = at;
        ph = PARSE_ERROR;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic has, logic last);
        logic [7:0]    idx;
        logic [7:0]    up;
        logic [1:0]    k;
        logic [2:0]    comp;
        vldp_word_t    w;
        status_claim_t claim;
        if (has)
        begin
            idx = char_pos;
            up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
            if (char_pos != 8'hFF)
                char_pos = char_pos + 8'd1;
            case (ph)
                AWAIT_I:
                    if (!is_blank(c))
                    begin
                        if (up == CH_I)
                        begin
                            letter_pos = idx;
                            ph = AWAIT_TRI;
                        end
                        else
                            set_error(ST_BAD_STRUCT, idx);
                    end
                AWAIT_TRI:
                    if (!is_blank(c))
                    begin
                        if (up == CH_L)
                        begin
                            tri_sel = PRIM_LIST;
                            ph = AWAIT_FIELD;
                        end
                        else if (up == CH_S)
                        begin
                            tri_sel = PRIM_STRIP;
                            ph = AWAIT_FIELD;
                        end
                        else
                            set_error(ST_BAD_TYPE, idx);
                    end
                AWAIT_FIELD:
                    if (!is_blank(c))
                    begin
                        if (up == CH_HASH)
                            ph = PARSE_DONE;
                        else if (up == CH_P || up == CH_N || up == CH_T || up == CH_C)
                        begin
                            pend_kind = (up == CH_P) ? KIND_POSITION :
                                        (up == CH_N) ? KIND_NORMAL :
                                        (up == CH_T) ? KIND_TEXTURE : KIND_COLOR;
                            letter_pos = idx;
                            ph = AWAIT_DIGIT;
                        end
                        else
                            set_error(ST_UNKNOWN, idx);
                    end
                AWAIT_DIGIT:
                begin
                    // The digit is taken as is: no whitespace or case folding here.
                    k = pend_kind;
                    if (c < CH_ONE || c > CH_FOUR)
                        set_error(ST_P_COUNT + {k, 1'b0}, letter_pos);
                    else if (used_count[k] >= ((k < KIND_TEXTURE) ? 1 : REPEAT_LIMIT))
                        set_error(ST_P_MANY + {k, 1'b0}, letter_pos);
                    else
                    begin
                        comp = 3'(c - CH_ZERO);
                        w = '0;
                        w.field_kind = k;
                        w.slot = used_count[k][3:0];
                        w.offset_bytes = stride;
                        w.components = comp;
                        expected_words.push_back(w);
                        stride = stride + {5'b0, comp, 2'b00};
                        used_count[k] = used_count[k] + 5'd1;
                        ph = AWAIT_FIELD;
                    end
                end
                default:
                    ;
            endcase
        end

        if (last)
        begin
            w = '0;
            w.is_status = 1'b1;
            w.tri_type = tri_sel;
            w.stride_bytes = stride;
            case (ph)
                PARSE_ERROR:
                begin
                    w.status = err_code;
                    w.error_index = err_pos;
                end
                AWAIT_I:
                    w.status = ST_EMPTY;
                AWAIT_TRI, AWAIT_DIGIT:
                begin
                    w.status = ST_UNEXP_END;
                    w.error_index = letter_pos;
                end
                default:
                    w.status = ST_OK;
            endcase
            // Directed descriptors may carry a status word typed in by hand.
            if (claimed_status.size() != 0)
            begin
                claim = claimed_status.pop_front();
                if (claim.fixed)
                    w = claim.word;
            end
            expected_words.push_back(w);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int want, int got);
        if (mismatch_count < 50)
            $display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_word(vldp_word_t want, vldp_word_t got);
        if (got.is_status !== want.is_status)
            report_mismatch("is_status", want.is_status, got.is_status);
        if (got.field_kind !== want.field_kind)
            report_mismatch("field_kind", want.field_kind, got.field_kind);
        if (got.slot !== want.slot)
            report_mismatch("slot", want.slot, got.slot);
        if (got.offset_bytes !== want.offset_bytes)
            report_mismatch("offset_bytes", want.offset_bytes, got.offset_bytes);
        if (got.components !== want.components)
            report_mismatch("components", want.components, got.components);
        if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
        if (got.tri_type !== want.tri_type)
            report_mismatch("tri_type", want.tri_type, got.tri_type);
        if (got.stride_bytes !== want.stride_bytes)
            report_mismatch("stride_bytes", want.stride_bytes, got.stride_bytes);
        if (got.error_index !== want.error_index)
            report_mismatch("error_index", want.error_index, got.error_index);
    endtask

    // Both channels are sampled at the rising edge. An output word is checked
    // before the input word of the same edge is predicted; the block cannot
    // turn an input word around within one edge, so the order is harmless.
    // The same process runs the watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen_word = {out_ch.is_status, out_ch.field_kind, out_ch.slot,
                             out_ch.offset_bytes, out_ch.components, out_ch.status,
                             out_ch.tri_type, out_ch.stride_bytes, out_ch.error_index};
                if (expected_words.size() == 0)
                    report_mismatch("word count, a word arrived with none pending", 0, 1);
                else
                    check_word(expected_words.pop_front(), seen_word);
            end
            if (in_ch.valid && in_ch.ready)
                predict_char(in_ch.char_code, in_ch.has_char, in_ch.end_of_text);

            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It changes style after each random span of cycles: always ready,
    // coin flips, sparse acceptance, a fixed cycle, and long stalls broken
    // by single accepting cycles.
    // ------------------------------------------------------------------
    initial begin : receiver
        ready_style_t style;
        int span;
        int stall_left;
        int cycle_count;
        out_ch.ready = 1'b0;
        stall_left = 0;
        cycle_count = 0;
        forever
        begin
            style = ready_style_t'($urandom_range(0, 4));
            span = $urandom_range(40, 250);
            repeat (span)
            begin
                @(negedge clk);
                cycle_count++;
                case (style)
                    READY_ALWAYS:
                        out_ch.ready <= 1'b1;
                    READY_HALF:
                        out_ch.ready <= ($urandom_range(0, 1) == 1);
                    READY_SPARSE:
                        out_ch.ready <= ($urandom_range(0, 3) == 0);
                    READY_CYCLIC:
                        out_ch.ready <= ((cycle_count % 7) < 4);
                    default:
                        if (stall_left > 0)
                        begin
                            out_ch.ready <= 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            out_ch.ready <= 1'b1;
                            stall_left = $urandom_range(4, 30);
                        end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts valid
    // drops for a random gap, or not at all. Now and then a burst is long
    // enough to run through several descriptors without a single idle cycle.
    // ------------------------------------------------------------------
    task automatic send_word(logic [7:0] c, logic has, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.char_code <= c;
        in_ch.has_char <= has;
        in_ch.end_of_text <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Sends the characters held in layout_chars as one descriptor. With noisy
    // set, words without a character are slipped in between at random.
    task automatic send_layout(bit blank_end, bit noisy);
        int n;
        n = layout_chars.size();
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(layout_chars[i], 1'b1, !blank_end && (i == n - 1));
        end
        if (blank_end || n == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Whitespace between tokens, some of the time.
    function automatic void add_blanks();
        logic [7:0] pick;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                pick = ($urandom_range(0, 1) == 0) ? CH_SPACE
                                                   : 8'($urandom_range(CH_TAB, CH_CR));
                layout_chars.push_back(pick);
            end
        end
    endfunction

    // Letters come in either case at random.
    function automatic logic [7:0] any_case(logic [7:0] letter);
        return ($urandom_range(0, 1) == 0) ? letter : letter | CASE_GAP;
    endfunction

    // Most random descriptors are well formed, so that the field limits and
    // the largest strides are reached; the rest carry a single flaw.
    function automatic void build_random_layout();
        layout_flaw_t flaw;
        int           pick;
        int           n_fields;
        int           flaw_at;
        logic [1:0]   k;
        bit           single_used [2];
        pick = $urandom_range(0, 19);
        flaw = (pick < 7) ? layout_flaw_t'(pick) : FLAW_NONE;
        layout_chars.delete();
        single_used = '{1'b0, 1'b0};

        if (flaw == FLAW_GARBAGE)
        begin
            repeat ($urandom_range(1, 6))
                layout_chars.push_back(8'($urandom));
            return;
        end

        add_blanks();
        layout_chars.push_back(any_case(CH_I));
        add_blanks();
        if (flaw == FLAW_TYPE)
            layout_chars.push_back(8'($urandom));
        else
            layout_chars.push_back(any_case(($urandom_range(0, 1) == 0) ? CH_L : CH_S));

        n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 36)
                                               : $urandom_range(0, 6);
        flaw_at = $urandom_range(0, n_fields);
        for (int f = 0; f < n_fields; f++)
        begin
            add_blanks();
            k = 2'($urandom_range(0, 3));
            // Position and normal are allowed once; repeat them only rarely.
            if (k < KIND_TEXTURE && single_used[k] && $urandom_range(0, 7) != 0)
                k = ($urandom_range(0, 1) == 0) ? KIND_TEXTURE : KIND_COLOR;
            if (k < KIND_TEXTURE)
                single_used[k] = 1'b1;
            if (flaw == FLAW_LETTER && f == flaw_at)
                layout_chars.push_back(8'($urandom));
            else
                layout_chars.push_back(any_case(field_letters[k]));
            if (flaw == FLAW_DIGIT && f == flaw_at)
                layout_chars.push_back(8'($urandom));
            else
                layout_chars.push_back(CH_ONE + 8'($urandom_range(0, 3)));
        end

        if (flaw == FLAW_COMMENT)
        begin
            add_blanks();
            layout_chars.push_back(CH_HASH);
            repeat ($urandom_range(0, 5))
                layout_chars.push_back(8'($urandom));
        end
        else if (flaw == FLAW_TRUNCATE)
            void'(layout_chars.pop_back());
        else
            add_blanks();
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, the directed descriptors, then random ones until
    // the word budget is spent, and finally a drain until every expected
    // word has come back.
    // ------------------------------------------------------------------
    initial begin : stimulus
        vldp_word_t stated;
        int         n;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.char_code = '0;
        in_ch.has_char = 1'b0;
        in_ch.end_of_text = 1'b0;
        clear_parser();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (layout_cases[r])
        begin
            layout_chars.delete();
            n = layout_cases[r].text.len();
            for (int i = 0; i < n; i++)
            begin
                if (i == n - 1)
                    repeat (layout_cases[r].pad) layout_chars.push_back(CH_SPACE);
                layout_chars.push_back(layout_cases[r].text[i]);
            end
            stated = '0;
            stated.is_status = 1'b1;
            stated.status = layout_cases[r].st;
            stated.tri_type = layout_cases[r].tri_k;
            stated.stride_bytes = 10'(layout_cases[r].stride);
            stated.error_index = 8'(layout_cases[r].err_at);
            // Every directed descriptor queues a claim, typed or not, so
            // that claims stay in step with descriptors.
            claimed_status.push_back({layout_cases[r].fixed, stated});
            send_layout(layout_cases[r].blank_end, 1'b0);
        end

        while (words_sent < TOTAL_WORDS)
        begin
            build_random_layout();
            send_layout(($urandom_range(0, 5) == 0), 1'b1);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        // The watchdog covers the case where the expected words never come.
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/vldp_pkg.sv
src/vldp_if.sv
src/vldp_front.sv
src/vldp_queue.sv
src/vldp_back.sv
src/vertex_layout_descriptor_parser_top.sv
sim/vertex_layout_descriptor_parser_top_test.sv
